FILE: src/qat_pkg.sv
// shared types and codes for the quoted argument tokenizer
// depends on nothing; imported by every module of the block
package qat_pkg;

  localparam int unsigned QAT_FIFO_DEPTH = 4;

  // result kinds
  localparam logic [2:0] K_BYTE    = 3'd0;
  localparam logic [2:0] K_ARGEND  = 3'd1;
  localparam logic [2:0] K_LINEOK  = 3'd2;
  localparam logic [2:0] K_LINEERR = 3'd3;
  localparam logic [2:0] K_DONE    = 3'd4;

  // line error codes
  localparam logic [2:0] E_NONE  = 3'd0;
  localparam logic [2:0] E_END   = 3'd1;
  localparam logic [2:0] E_ESC   = 3'd2;
  localparam logic [2:0] E_QUOTE = 3'd3;
  localparam logic [2:0] E_GLOM  = 3'd4;

  // byte values with a meaning of their own
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] arg_byte;
    logic [2:0] error_code;
  } res_t;

  // one or two results caused by one input byte
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [7:0] b, logic [2:0] e);
    res_t r;
    r.kind       = kind;
    r.arg_byte   = b;
    r.error_code = e;
    return r;
  endfunction

endpackage

FILE: src/quoted_argument_tokenizer.sv
// top level of the quoted argument tokenizer: front end, entry queue, sequencer
// depends on qat_pkg, qat_front, qat_fifo and qat_back
//
// channel   direction  handshake          payload
// in_       in         in_push / in_full  in_ch[7:0], in_at_end
// out_      out        out_pop / out_empty out_kind[2:0], out_arg_byte[7:0],
//                                          out_error_code[2:0], out_last
//
// one byte is taken per cycle while in_full is low; the front end decides all results of a byte
// in the cycle it is taken and queues them as one entry
// results are registered in the entry queue before they reach the output; a byte with two results holds
// the output for two pops, so such bytes cost an extra pop on the output side
// in_full rises only when the FIFO_DEPTH entry queue is full
// synchronous active-low reset: line start mode, queue empty
module quoted_argument_tokenizer #(
  parameter int unsigned FIFO_DEPTH = qat_pkg::QAT_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_ch,
  input  logic       in_at_end,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [2:0] out_kind,
  output logic [7:0] out_arg_byte,
  output logic [2:0] out_error_code,
  output logic       out_last
);
  import qat_pkg::*;

  logic   acc;       // input request taken this cycle
  logic   f_has;     // taken byte causes at least one result
  entry_t f_ent;     // results of the taken byte
  entry_t q_ent;     // oldest queued entry
  logic   q_empty;
  logic   q_pop;

  assign acc = in_push && !in_full;

  // classifies bytes and advances the tokenizer mode
  qat_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .ch      (in_ch),
    .at_end  (in_at_end),
    .has_res (f_has),
    .ent     (f_ent)
  );

  // decouples byte intake from result delivery
  qat_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (acc && f_has),
    .wdata (f_ent),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_ent),
    .empty (q_empty)
  );

  // splits double entries into two result requests
  qat_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .ent            (q_ent),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_kind       (out_kind),
    .out_arg_byte   (out_arg_byte),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

`ifndef SYNTH
  // a byte that causes results is visible on the output in the next cycle
  a_res_visible: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && f_has) |=> !out_empty)
    else $error("queued result not visible");

  // the first of two results is always followed by the second
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_last) |=> !out_empty)
    else $error("second result lost");

  // only line errors carry an error code
  a_err_only_lineerr: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_kind != K_LINEERR)) |-> (out_error_code == E_NONE))
    else $error("error code on non-error result");

  // argument bytes are only ever reported as the byte itself, never zero
  a_byte_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_kind == K_BYTE)) |-> (out_arg_byte != CH_NUL))
    else $error("zero argument byte");
`endif

endmodule

FILE: src/qat_front.sv
// front end: classifies each input byte and runs the tokenizer state machine
// depends on qat_pkg; produces one queue entry per byte that causes results
module qat_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  logic [7:0]      ch,
  input  logic            at_end,
  output logic            has_res,
  output qat_pkg::entry_t ent
);
  import qat_pkg::*;

  localparam logic [2:0] M_START   = 3'd0;
  localparam logic [2:0] M_BETWEEN = 3'd1;
  localparam logic [2:0] M_PLAIN   = 3'd2;
  localparam logic [2:0] M_QUOTED  = 3'd3;
  localparam logic [2:0] M_COMMENT = 3'd4;
  localparam logic [2:0] M_DROP    = 3'd5;
  localparam logic [2:0] M_AFTERQ  = 3'd6;
  localparam logic [2:0] M_CRSKIP  = 3'd7;

  logic [2:0] mode_r, mode_nxt;
  logic       esc_r, esc_nxt;

  logic       nul, is_ws;
  logic [2:0] bw_mode;
  logic       bw_esc, bw_has;
  res_t       bw_res;
  logic       has0, two;
  res_t       r0, r1;

  assign nul   = at_end || (ch == CH_NUL);
  assign is_ws = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_CR) ||
                 (ch == CH_VT) || (ch == CH_FF);

  // outcome of a byte seen between arguments
  always_comb begin
    bw_mode = M_START;
    bw_esc  = 1'b0;
    bw_has  = 1'b0;
    bw_res  = mk_res(K_BYTE, CH_NUL, E_NONE);
    if (nul) begin
      bw_has = 1'b1;
      bw_res = mk_res(K_LINEERR, CH_NUL, E_END);
    end else begin
      unique case (ch)
        CH_SPACE, CH_TAB: bw_mode = M_BETWEEN;
        CH_LF: begin
          bw_has = 1'b1;
          bw_res = mk_res(K_LINEOK, CH_NUL, E_NONE);
        end
        CH_CR: begin
          bw_mode = M_DROP;
          bw_has  = 1'b1;
          bw_res  = mk_res(K_LINEOK, CH_NUL, E_NONE);
        end
        CH_SEMI:  bw_mode = M_COMMENT;
        CH_QUOTE: bw_mode = M_QUOTED;
        CH_BSL: begin
          bw_mode = M_PLAIN;
          bw_esc  = 1'b1;
        end
        default: begin
          bw_mode = M_PLAIN;
          bw_has  = 1'b1;
          bw_res  = mk_res(K_BYTE, ch, E_NONE);
        end
      endcase
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    has0     = 1'b0;
    two      = 1'b0;
    r0       = mk_res(K_BYTE, CH_NUL, E_NONE);
    r1       = mk_res(K_BYTE, CH_NUL, E_NONE);
    unique case (mode_r)
      M_START: begin
        if (at_end) begin
          has0 = 1'b1;
          r0   = mk_res(K_DONE, CH_NUL, E_NONE);
        end else begin
          mode_nxt = bw_mode;
          esc_nxt  = bw_esc;
          has0     = bw_has;
          r0       = bw_res;
        end
      end
      M_BETWEEN: begin
        mode_nxt = bw_mode;
        esc_nxt  = bw_esc;
        has0     = bw_has;
        r0       = bw_res;
      end
      M_CRSKIP: begin
        if (at_end || (ch != CH_CR)) begin
          mode_nxt = bw_mode;
          esc_nxt  = bw_esc;
          has0     = bw_has;
          r0       = bw_res;
        end
      end
      M_DROP: begin
        if (at_end) begin
          mode_nxt = M_START;
          has0     = 1'b1;
          r0       = mk_res(K_DONE, CH_NUL, E_NONE);
        end else if (ch != CH_CR) begin
          mode_nxt = M_START;
        end
      end
      M_COMMENT: begin
        if (nul) begin
          mode_nxt = M_START;
          esc_nxt  = 1'b0;
          has0     = 1'b1;
          r0       = mk_res(K_LINEERR, CH_NUL, E_END);
        end else if (ch == CH_LF) begin
          mode_nxt = M_START;
          has0     = 1'b1;
          r0       = mk_res(K_LINEOK, CH_NUL, E_NONE);
        end else if (ch == CH_CR) begin
          mode_nxt = M_CRSKIP;
        end
      end
      M_PLAIN, M_QUOTED: begin
        if (esc_r) begin
          has0 = 1'b1;
          if (nul) begin
            mode_nxt = M_START;
            esc_nxt  = 1'b0;
            r0       = mk_res(K_LINEERR, CH_NUL, E_ESC);
          end else begin
            esc_nxt = 1'b0;
            r0      = mk_res(K_BYTE, ch, E_NONE);
          end
        end else if (mode_r == M_QUOTED) begin
          if (nul) begin
            mode_nxt = M_START;
            has0     = 1'b1;
            r0       = mk_res(K_LINEERR, CH_NUL, E_QUOTE);
          end else if (ch == CH_BSL) begin
            esc_nxt = 1'b1;
          end else if (ch == CH_QUOTE) begin
            mode_nxt = M_AFTERQ;
          end else begin
            has0 = 1'b1;
            r0   = mk_res(K_BYTE, ch, E_NONE);
          end
        end else begin
          // open plain argument
          if (nul) begin
            mode_nxt = M_START;
            has0     = 1'b1;
            two      = 1'b1;
            r0       = mk_res(K_ARGEND, CH_NUL, E_NONE);
            r1       = mk_res(K_LINEERR, CH_NUL, E_END);
          end else if (ch == CH_BSL) begin
            esc_nxt = 1'b1;
          end else if ((ch == CH_SPACE) || (ch == CH_TAB)) begin
            mode_nxt = M_BETWEEN;
            has0     = 1'b1;
            r0       = mk_res(K_ARGEND, CH_NUL, E_NONE);
          end else if (ch == CH_LF) begin
            mode_nxt = M_START;
            has0     = 1'b1;
            two      = 1'b1;
            r0       = mk_res(K_ARGEND, CH_NUL, E_NONE);
            r1       = mk_res(K_LINEOK, CH_NUL, E_NONE);
          end else if (ch == CH_CR) begin
            mode_nxt = M_CRSKIP;
            has0     = 1'b1;
            r0       = mk_res(K_ARGEND, CH_NUL, E_NONE);
          end else begin
            has0 = 1'b1;
            r0   = mk_res(K_BYTE, ch, E_NONE);
          end
        end
      end
      M_AFTERQ: begin
        has0 = 1'b1;
        if (at_end || !is_ws) begin
          mode_nxt = M_START;
          esc_nxt  = 1'b0;
          r0       = mk_res(K_LINEERR, CH_NUL, E_GLOM);
        end else begin
          // whitespace closes the argument, then acts as between arguments
          mode_nxt = bw_mode;
          esc_nxt  = bw_esc;
          r0       = mk_res(K_ARGEND, CH_NUL, E_NONE);
          two      = bw_has;
          r1       = bw_res;
        end
      end
      default: mode_nxt = M_START;
    endcase
  end

  assign has_res = has0;
  assign ent.two = two;
  assign ent.r0  = r0;
  assign ent.r1  = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_START;
      esc_r  <= 1'b0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
    end
  end

endmodule

FILE: src/qat_fifo.sv
// short entry queue between the front end and the result sequencer
// depends on qat_pkg for the entry type
module qat_fifo #(
  parameter int unsigned DEPTH = qat_pkg::QAT_FIFO_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  qat_pkg::entry_t wdata,
  output logic            full,
  input  logic            pop,
  output qat_pkg::entry_t rdata,
  output logic            empty
);
  import qat_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: src/qat_back.sv
// result sequencer: hands out the one or two results of each queued entry
// depends on qat_pkg for the entry type
module qat_back (
  input  logic            clk,
  input  logic            rst_n,
  input  qat_pkg::entry_t ent,
  input  logic            q_empty,
  output logic            q_pop,
  input  logic            out_pop,
  output logic            out_empty,
  output logic [2:0]      out_kind,
  output logic [7:0]      out_arg_byte,
  output logic [2:0]      out_error_code,
  output logic            out_last
);
  import qat_pkg::*;

  logic sub_r, sub_nxt;
  logic take;
  res_t cur;

  assign take      = out_pop && !q_empty;
  assign cur       = sub_r ? ent.r1 : ent.r0;
  assign out_last  = !ent.two || sub_r;
  assign q_pop     = take && out_last;
  assign sub_nxt   = take ? !out_last : sub_r;
  assign out_empty = q_empty;

  assign out_kind       = cur.kind;
  assign out_arg_byte   = cur.arg_byte;
  assign out_error_code = cur.error_code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
    end
  end

endmodule

FILE: sim/quoted_argument_tokenizer_test.sv
// self-checking bench for quoted_argument_tokenizer: directed byte table, then random command lines
// depends on qat_pkg (kind, error and byte codes) and the tokenizer rtl; needs nothing else
module quoted_argument_tokenizer_test;
  import qat_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 800;
  localparam int N_DIRECTED   = 25;

  // scanner modes of the tokenizer, as the bench tracks them
  typedef enum logic [2:0] {
    LINE_START, GAP, PLAIN_ARG, QUOTED_ARG, COMMENT_TEXT, CR_DROP, AFTER_QUOTE, CR_SKIP
  } scan_mode_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] arg_byte;
    logic [2:0] error_code;
    logic       last;
  } token_t;

  // one directed request; typed rows carry their single expected token
  typedef struct packed {
    logic [7:0] ch;
    logic       at_end;
    logic       typed;
    token_t     tok;
  } stim_row_t;

  localparam token_t NO_TOKEN = '0;

  // walks through every mode but GAP, and every error code; rows with typed = 0 go to the predictor
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    {8'hFF,    1'b1, 1'b1, K_DONE,    8'h00, E_NONE,  1'b1}, // end at line start, ch ignored
    {CH_NUL,   1'b0, 1'b1, K_LINEERR, 8'h00, E_END,   1'b1}, // nul at line start
    {8'hFF,    1'b0, 1'b1, K_BYTE,    8'hFF, E_NONE,  1'b1}, // top byte opens an argument
    {CH_BSL,   1'b0, 1'b0, NO_TOKEN},
    {CH_NUL,   1'b0, 1'b1, K_LINEERR, 8'h00, E_ESC,   1'b1}, // nul after backslash
    {CH_QUOTE, 1'b0, 1'b0, NO_TOKEN},
    {CH_BSL,   1'b0, 1'b0, NO_TOKEN},
    {CH_QUOTE, 1'b0, 1'b1, K_BYTE,    CH_QUOTE, E_NONE, 1'b1}, // escaped quote inside quotes
    {CH_QUOTE, 1'b0, 1'b0, NO_TOKEN},
    {CH_VT,    1'b0, 1'b0, NO_TOKEN},                    // vertical tab after quote: two tokens
    {CH_CR,    1'b0, 1'b1, K_ARGEND,  8'h00, E_NONE,  1'b1}, // cr inside a plain argument
    {CH_CR,    1'b0, 1'b0, NO_TOKEN},
    {CH_SEMI,  1'b0, 1'b0, NO_TOKEN},
    {CH_CR,    1'b0, 1'b0, NO_TOKEN},
    {CH_LF,    1'b0, 1'b1, K_LINEOK,  8'h00, E_NONE,  1'b1},
    {CH_QUOTE, 1'b0, 1'b0, NO_TOKEN},
    {8'h00,    1'b1, 1'b1, K_LINEERR, 8'h00, E_QUOTE, 1'b1}, // end inside quotes
    {CH_QUOTE, 1'b0, 1'b0, NO_TOKEN},
    {CH_QUOTE, 1'b0, 1'b0, NO_TOKEN},
    {8'h7A,    1'b0, 1'b1, K_LINEERR, 8'h00, E_GLOM,  1'b1}, // text glued to the closing quote
    {CH_CR,    1'b0, 1'b1, K_LINEOK,  8'h00, E_NONE,  1'b1}, // cr ends an empty line
    {CH_CR,    1'b0, 1'b0, NO_TOKEN},
    {8'h00,    1'b1, 1'b1, K_DONE,    8'h00, E_NONE,  1'b1}, // end where the dropped byte was due
    {8'h6B,    1'b0, 1'b0, NO_TOKEN},
    {8'h00,    1'b1, 1'b0, NO_TOKEN}                     // end mid-argument: arg end then error
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_ch = 8'h00;
  logic       in_at_end = 1'b0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [2:0] out_kind;
  logic [7:0] out_arg_byte;
  logic [2:0] out_error_code;
  logic       out_last;

  quoted_argument_tokenizer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_ch          (in_ch),
    .in_at_end      (in_at_end),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_kind       (out_kind),
    .out_arg_byte   (out_arg_byte),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // token predictor: a private copy of the scanner state, stepped once per
  // accepted request; the tokens of one step land in step_tok[0..step_cnt-1]
  // ---------------------------------------------------------------------------
  scan_mode_e scan_mode = LINE_START;
  logic       escape_seen = 1'b0;
  token_t     step_tok [2];
  int         step_cnt;

  token_t     token_queue [$];     // tokens still owed by the block, oldest first
  int         failures = 0;
  int         sent = 0;
  int         in_idle_pct = 0;
  int         out_idle_pct = 0;
  int         cycles = 0;

  function void emit(input logic [2:0] kind, input logic [7:0] b, input logic [2:0] e);
    step_tok[step_cnt] = {kind, b, e, 1'b0};
    step_cnt++;
  endfunction

  // every error drops back to line start and forgets a pending backslash
  function void line_error(input logic [2:0] e);
    scan_mode   = LINE_START;
    escape_seen = 1'b0;
    emit(K_LINEERR, 8'h00, e);
  endfunction

  // a byte seen between arguments, also used for line start and after whitespace
  function void gap_byte(input logic [7:0] c, input logic fin);
    escape_seen = 1'b0;
    if (fin || c == CH_NUL) begin
      line_error(E_END);
    end else begin
      case (c)
        CH_SPACE, CH_TAB: scan_mode = GAP;
        CH_LF: begin
          scan_mode = LINE_START;
          emit(K_LINEOK, 8'h00, E_NONE);
        end
        CH_CR: begin
          // line ends, and the first byte that is not a cr gets swallowed
          scan_mode = CR_DROP;
          emit(K_LINEOK, 8'h00, E_NONE);
        end
        CH_SEMI:  scan_mode = COMMENT_TEXT;
        CH_QUOTE: scan_mode = QUOTED_ARG;
        CH_BSL: begin
          scan_mode   = PLAIN_ARG;
          escape_seen = 1'b1;
        end
        default: begin
          scan_mode = PLAIN_ARG;
          emit(K_BYTE, c, E_NONE);
        end
      endcase
    end
  endfunction

  function void tokenize_byte(input logic [7:0] c, input logic fin);
    logic nul;
    nul      = fin || c == CH_NUL;
    step_cnt = 0;
    case (scan_mode)
      LINE_START: begin
        if (fin) emit(K_DONE, 8'h00, E_NONE);
        else gap_byte(c, 1'b0);
      end
      GAP: gap_byte(c, fin);
      CR_SKIP: begin
        // further crs inside a line are skipped silently
        if (fin || c != CH_CR) gap_byte(c, fin);
      end
      CR_DROP: begin
        if (fin) begin
          scan_mode = LINE_START;
          emit(K_DONE, 8'h00, E_NONE);
        end else if (c != CH_CR) begin
          scan_mode = LINE_START;
        end
      end
      COMMENT_TEXT: begin
        if (nul) begin
          line_error(E_END);
        end else if (c == CH_LF) begin
          scan_mode = LINE_START;
          emit(K_LINEOK, 8'h00, E_NONE);
        end else if (c == CH_CR) begin
          scan_mode = CR_SKIP;
        end
      end
      PLAIN_ARG: begin
        if (escape_seen) begin
          if (nul) begin
            line_error(E_ESC);
          end else begin
            escape_seen = 1'b0;
            emit(K_BYTE, c, E_NONE);
          end
        end else if (nul) begin
          emit(K_ARGEND, 8'h00, E_NONE);
          line_error(E_END);
        end else if (c == CH_BSL) begin
          escape_seen = 1'b1;
        end else if (c == CH_SPACE || c == CH_TAB) begin
          scan_mode = GAP;
          emit(K_ARGEND, 8'h00, E_NONE);
        end else if (c == CH_LF) begin
          scan_mode = LINE_START;
          emit(K_ARGEND, 8'h00, E_NONE);
          emit(K_LINEOK, 8'h00, E_NONE);
        end else if (c == CH_CR) begin
          scan_mode = CR_SKIP;
          emit(K_ARGEND, 8'h00, E_NONE);
        end else begin
          emit(K_BYTE, c, E_NONE);
        end
      end
      QUOTED_ARG: begin
        if (escape_seen) begin
          if (nul) begin
            line_error(E_ESC);
          end else begin
            escape_seen = 1'b0;
            emit(K_BYTE, c, E_NONE);
          end
        end else if (nul) begin
          line_error(E_QUOTE);
        end else if (c == CH_BSL) begin
          escape_seen = 1'b1;
        end else if (c == CH_QUOTE) begin
          scan_mode = AFTER_QUOTE;
        end else begin
          emit(K_BYTE, c, E_NONE);
        end
      end
      default: begin
        // after a closing quote only whitespace may follow; vt and ff count too
        if (fin || !(c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
                     c == CH_VT || c == CH_FF)) begin
          line_error(E_GLOM);
        end else begin
          emit(K_ARGEND, 8'h00, E_NONE);
          gap_byte(c, 1'b0);
        end
      end
    endcase
    if (step_cnt > 0) step_tok[step_cnt - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // request side: hold the request until in_full is seen low at an edge,
  // then book what it owes; typed rows replace the predictor's tokens
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] c, input logic fin,
                           input logic typed = 1'b0, input token_t tok = NO_TOKEN);
    while ($urandom_range(99) < in_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push   <= 1'b1;
    in_ch     <= c;
    in_at_end <= fin;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sent++;
    tokenize_byte(c, fin);
    if (typed) begin
      token_queue.push_back(tok);
    end else begin
      for (int i = 0; i < step_cnt; i++) token_queue.push_back(step_tok[i]);
    end
  endtask

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
           c == CH_QUOTE || c == CH_SEMI || c == CH_BSL);
    return c;
  endfunction

  function automatic logic [7:0] pick_quoted();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == CH_QUOTE || c == CH_BSL);
    return c;
  endfunction

  function automatic logic [7:0] pick_blank();
    return $urandom_range(1) ? CH_SPACE : CH_TAB;
  endfunction

  // mostly well-formed command lines with random content, some noise and broken lines
  task automatic random_line();
    int pick;
    int nargs;
    pick  = $urandom_range(99);
    nargs = $urandom_range(0, 4);
    if (pick < 6) begin
      // raw noise, any byte, end marks now and then
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
      return;
    end
    if (pick < 11) begin
      send_byte(8'($urandom_range(255)), 1'b1);
      return;
    end
    if ($urandom_range(3) == 0) send_byte(pick_blank(), 1'b0);
    for (int a = 0; a < nargs; a++) begin
      if (a > 0) repeat ($urandom_range(1, 2)) send_byte(pick_blank(), 1'b0);
      if ($urandom_range(9) < 4) begin
        send_byte(CH_QUOTE, 1'b0);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(7) == 0) begin
            send_byte(CH_BSL, 1'b0);
            send_byte(8'($urandom_range(1, 255)), 1'b0);
          end else begin
            send_byte(pick_quoted(), 1'b0);
          end
        end
        send_byte(CH_QUOTE, 1'b0);
        // odd things right after the closing quote
        case ($urandom_range(9))
          0: send_byte(pick_plain(), 1'b0);
          1: send_byte($urandom_range(1) ? CH_VT : CH_FF, 1'b0);
          default: ;
        endcase
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(7) == 0) begin
            send_byte(CH_BSL, 1'b0);
            send_byte(8'($urandom_range(1, 255)), 1'b0);
          end else begin
            send_byte(pick_plain(), 1'b0);
          end
        end
      end
    end
    if ($urandom_range(4) == 0) begin
      send_byte(pick_blank(), 1'b0);
      send_byte(CH_SEMI, 1'b0);
      repeat ($urandom_range(0, 5)) begin
        if ($urandom_range(9) == 0) send_byte(CH_CR, 1'b0);
        else send_byte(pick_plain(), 1'b0);
      end
    end
    pick = $urandom_range(19);
    if (pick == 0) begin
      send_byte(CH_NUL, 1'($urandom_range(1)));
    end else if (pick == 1) begin
      send_byte(CH_BSL, 1'b0);
      send_byte(CH_NUL, 1'($urandom_range(1)));
    end else if (pick < 7) begin
      // cr at the end; where it ends the line, the next line loses its first byte unless it is a cr
      send_byte(CH_CR, 1'b0);
      repeat ($urandom_range(0, 2)) send_byte(CH_CR, 1'b0);
    end else begin
      send_byte(CH_LF, 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random pop, each popped token checked field by field
  // ---------------------------------------------------------------------------
  function void report_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    token_t want;
    out_pop <= ($urandom_range(99) >= out_idle_pct);
    if (rst_n && out_pop && !out_empty) begin
      if (token_queue.size() == 0) begin
        $display("%0t: token with nothing expected, expected none, actual kind %0d",
                 $time, out_kind);
        failures++;
      end else begin
        want = token_queue.pop_front();
        report_field("kind", int'(want.kind), int'(out_kind));
        report_field("arg_byte", int'(want.arg_byte), int'(out_arg_byte));
        report_field("error_code", int'(want.error_code), int'(out_error_code));
        report_field("last", int'(want.last), int'(out_last));
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("quoted_argument_tokenizer verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // run: reset, directed table, three pacing phases of random lines, drain
  // ---------------------------------------------------------------------------
  initial begin
    in_idle_pct  = 11;
    out_idle_pct = 66;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++)
      send_byte(DIRECTED[i].ch, DIRECTED[i].at_end, DIRECTED[i].typed, DIRECTED[i].tok);

    while (sent < N_DIRECTED + RANDOM_ITEMS) begin
      // slow sender with fast receiver, then no idling at all
      if (sent >= N_DIRECTED + 2 * RANDOM_ITEMS / 3) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else if (sent >= N_DIRECTED + RANDOM_ITEMS / 3) begin
        in_idle_pct  = 66;
        out_idle_pct = 11;
      end
      random_line();
    end
    in_push <= 1'b0;

    // drain, then wait so that stray tokens can show up
    while (token_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("quoted_argument_tokenizer verification clean");
    end else begin
      $display("quoted_argument_tokenizer verification failed");
    end
    $finish;
  end

endmodule
